@@ rtl/gre_pkg.sv @@
// Shared types and constants for the gyro rate and heading estimator.
package gre_pkg;

    // Field widths
    localparam int RAW_W   = 16;
    localparam int SUM_W   = 26;
    localparam int RATE_W  = 32;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 31;
    localparam int DIV_W   = 16;
    localparam int WIDE_W  = 64;
    localparam int STEP_W  = 7;

    typedef logic [1:0]          cmd_t;
    typedef logic [1:0]          cfg_idx_t;
    typedef logic signed [RAW_W-1:0]  raw_t;
    typedef logic signed [RATE_W-1:0] rate_t;

    // Command codes
    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_EVAL   = 2'd1;
    localparam cmd_t CMD_CLEAR  = 2'd2;
    localparam cmd_t CMD_BIAS   = 2'd3;

    // Register indexes
    localparam cfg_idx_t CFG_SCALE    = 2'd0;
    localparam cfg_idx_t CFG_SMOOTH   = 2'd1;
    localparam cfg_idx_t CFG_DEADBAND = 2'd2;
    localparam cfg_idx_t CFG_BCOUNT   = 2'd3;

    // Register reset values
    localparam logic [23:0] SCALE_RST    = 24'd20370;
    localparam logic [16:0] SMOOTH_RST   = 17'd65536;
    localparam logic [30:0] DEADBAND_RST = 31'd1144;
    localparam logic [9:0]  BCOUNT_RST   = 10'd400;

    // Unity smoothing weight in Q1.16 and milliseconds per second
    localparam logic [16:0]      SMOOTH_ONE = 17'h10000;
    localparam logic [DIV_W-1:0] MS_PER_S   = 16'd1000;

    // Serial step counts
    localparam logic [STEP_W-1:0] SUM_STEPS   = 7'd26;
    localparam logic [STEP_W-1:0] SCALE_STEPS = 7'd24;
    localparam logic [STEP_W-1:0] MIX_STEPS   = 7'd17;
    localparam logic [STEP_W-1:0] DT_STEPS    = 7'd32;
    localparam logic [STEP_W-1:0] HDIV_STEPS  = 7'd64;

endpackage

@@ rtl/gyro_rate_heading_estimator.sv @@
// Gyro front end: sample sums, bias, scaled smoothed rates and heading.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  cfg     | in        | cfg_we               | cfg_index, cfg_data
//  in      | in        | in_valid / in_stall  | command, raw_x, raw_y, raw_z, time_ms
//  out     | out       | out_valid / out_stall| rate_x, rate_y, rate_z, heading, status
//
//  Sample and clear go straight to the output register. Evaluate is worked by
//  one shared bit-serial divider (one quotient bit a cycle) and one shift-add
//  multiplier (one multiplier bit a cycle); bias uses the divider alone.
//  One word is in flight at a time.
//  Reset clears sums, biases, rates, heading and time; no clearing pass.
//  A stalled result sits in the output register while the next word is worked.
module gyro_rate_heading_estimator #(
    parameter int MAX_SAMPLES = 1023
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  gre_pkg::cfg_idx_t    cfg_index,
    input  logic [30:0]          cfg_data,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  gre_pkg::cmd_t        command,
    input  gre_pkg::raw_t        raw_x,
    input  gre_pkg::raw_t        raw_y,
    input  gre_pkg::raw_t        raw_z,
    input  logic [31:0]          time_ms,
    // result words
    output logic                 out_valid,
    input  logic                 out_stall,
    output gre_pkg::rate_t       rate_x,
    output gre_pkg::rate_t       rate_y,
    output gre_pkg::rate_t       rate_z,
    output gre_pkg::rate_t       heading,
    output logic                 status
);
    import gre_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // State codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_BIAS  = 4'd1;
    localparam logic [3:0] S_MEAN  = 4'd2;
    localparam logic [3:0] S_SCALE = 4'd3;
    localparam logic [3:0] S_MIX1  = 4'd4;
    localparam logic [3:0] S_MIX2  = 4'd5;
    localparam logic [3:0] S_HCHK  = 4'd6;
    localparam logic [3:0] S_HMUL  = 4'd7;
    localparam logic [3:0] S_HDIV  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Configuration registers
    logic [23:0] scale_reg;
    logic [16:0] smooth_reg;
    logic [30:0] deadband_reg;
    logic [9:0]  bcount_reg;

    // Block state
    logic signed [SUM_W-1:0]  sum_reg  [3];
    logic [CNT_W-1:0]         cnt_reg;
    logic signed [RAW_W-1:0]  bias_reg [3];
    logic signed [RATE_W-1:0] rate_reg [3];
    logic signed [RATE_W-1:0] head_reg;
    logic [TIME_W-1:0]        last_reg;

    // Sequencer
    logic [3:0]        state_reg;
    logic [1:0]        ax_reg;
    logic [STEP_W-1:0] step_reg;
    logic              neg_reg;
    logic              status_reg;
    logic [TIME_W-1:0] time_reg;
    logic signed [RATE_W-1:0] nv_reg;

    // Serial divider and multiplier
    logic [WIDE_W-1:0]        dvd_reg;
    logic [DIV_W-1:0]         rem_reg;
    logic [DIV_W-1:0]         dsr_reg;
    logic signed [WIDE_W-1:0] acc_reg;
    logic signed [WIDE_W-1:0] mcand_reg;
    logic [31:0]              mplier_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [RATE_W-1:0] out_rate_reg [3];
    logic signed [RATE_W-1:0] out_head_reg;
    logic                     out_status_reg;

    // Divider step: shift one dividend bit into the remainder
    logic [DIV_W:0]   div_part;
    logic             div_ge;
    logic [DIV_W-1:0] rem_next;
    logic [WIDE_W-1:0] dvd_next;
    always_comb
    begin
        div_part = {rem_reg, dvd_reg[WIDE_W-1]};
        div_ge   = div_part >= {1'b0, dsr_reg};
        rem_next = div_ge ? DIV_W'(div_part - {1'b0, dsr_reg}) : div_part[DIV_W-1:0];
        dvd_next = {dvd_reg[WIDE_W-2:0], div_ge};
    end

    // Multiplier step: add shifted multiplicand on a set multiplier bit
    logic signed [WIDE_W-1:0] acc_next;
    assign acc_next = mplier_reg[0] ? acc_reg + mcand_reg : acc_reg;

    // Next axis operands
    logic [SUM_W-1:0]        nxt_sum_abs;
    logic                    nxt_sum_neg;
    // next axis (ax_reg + 1) for reloading the divider
    always_comb
    begin
        case (ax_reg)
            2'd0:    nxt_sum_neg = sum_reg[1][SUM_W-1];
            default: nxt_sum_neg = sum_reg[2][SUM_W-1];
        endcase
        case (ax_reg)
            2'd0:
                nxt_sum_abs = sum_reg[1][SUM_W-1] ? SUM_W'(-sum_reg[1])
                                                  : SUM_W'(sum_reg[1]);
            default:
                nxt_sum_abs = sum_reg[2][SUM_W-1] ? SUM_W'(-sum_reg[2])
                                                  : SUM_W'(sum_reg[2]);
        endcase
    end

    // Quotient with sign, mean minus bias (negated on z)
    logic [SUM_W-1:0]         quo;
    logic signed [SUM_W:0]    quo_s;
    logic signed [SUM_W+1:0]  adc;
    logic [SUM_W+1:0]         adc_abs;
    logic signed [RAW_W-1:0]  bias_sat;
    assign quo   = dvd_reg[SUM_W-1:0];
    assign quo_s = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    always_comb
    begin
        if (ax_reg == 2'd2)
            adc = (SUM_W+2)'(bias_reg[ax_reg]) - (SUM_W+2)'(quo_s);
        else
            adc = (SUM_W+2)'(quo_s) - (SUM_W+2)'(bias_reg[ax_reg]);
        adc_abs = adc[SUM_W+1] ? (SUM_W+2)'(-adc) : (SUM_W+2)'(adc);
        if (!neg_reg && quo > SUM_W'(32767))
            bias_sat = 16'sh7FFF;
        else if (neg_reg && quo > SUM_W'(32768))
            bias_sat = -16'sh8000;
        else
            bias_sat = RAW_W'(quo_s);
    end

    // Scaled rate: product / 256 toward zero, saturated to 32 bits
    logic [WIDE_W-9:0]        sh;
    logic signed [RATE_W-1:0] nv_next;
    assign sh = acc_reg[WIDE_W-1:8];
    always_comb
    begin
        if (!neg_reg && sh > (WIDE_W-8)'(32'h7FFFFFFF))
            nv_next = 32'sh7FFFFFFF;
        else if (neg_reg && sh > (WIDE_W-8)'(32'h80000000))
            nv_next = -32'sh80000000;
        else if (neg_reg)
            nv_next = RATE_W'(-$signed(sh));
        else
            nv_next = RATE_W'(sh);
    end

    // Smoothing weight and blended rate / 65536 toward zero
    logic [16:0]              f_w;
    logic [16:0]              f_inv;
    logic signed [WIDE_W-1:0] mix_rnd;
    logic signed [RATE_W-1:0] mix_rate;
    assign f_w      = (smooth_reg > SMOOTH_ONE) ? SMOOTH_ONE : smooth_reg;
    assign f_inv    = SMOOTH_ONE - f_w;
    assign mix_rnd  = acc_reg + (acc_reg[WIDE_W-1] ? 64'sd65535 : 64'sd0);
    assign mix_rate = mix_rnd[47:16];

    // Heading check on z rate
    logic [RATE_W-1:0] rz_abs;
    logic [RATE_W-1:0] hq;
    assign rz_abs = rate_reg[2][RATE_W-1] ? RATE_W'(-rate_reg[2]) : RATE_W'(rate_reg[2]);
    assign hq     = dvd_reg[RATE_W-1:0];

    logic [DIV_W-1:0] bdiv;
    assign bdiv = (bcount_reg == 10'd0) ? DIV_W'(1) : DIV_W'(bcount_reg);

    logic in_acc;
    assign in_acc   = in_valid && !in_stall;
    assign in_stall = state_reg != S_IDLE;

    // Result word moves into the output register
    logic out_load;
    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || !out_stall);

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_RST;
            smooth_reg   <= SMOOTH_RST;
            deadband_reg <= DEADBAND_RST;
            bcount_reg   <= BCOUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCALE:    scale_reg    <= cfg_data[23:0];
                CFG_SMOOTH:   smooth_reg   <= cfg_data[16:0];
                CFG_DEADBAND: deadband_reg <= cfg_data;
                CFG_BCOUNT:   bcount_reg   <= cfg_data[9:0];
                default:      scale_reg    <= scale_reg;
            endcase
        end
    end

    // Sequencer and block state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ax_reg     <= 2'd0;
            status_reg <= 1'b0;
            cnt_reg    <= '0;
            head_reg   <= '0;
            last_reg   <= '0;
            for (int i = 0; i < 3; i++)
            begin
                sum_reg[i]  <= '0;
                bias_reg[i] <= '0;
                rate_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        status_reg <= 1'b0;
                        ax_reg     <= 2'd0;
                        state_reg  <= S_OUT;
                        case (command)
                            CMD_SAMPLE:
                            begin
                                if (cnt_reg < CNT_W'(MAX_SAMPLES))
                                begin
                                    sum_reg[0] <= sum_reg[0] + SUM_W'(raw_x);
                                    sum_reg[1] <= sum_reg[1] + SUM_W'(raw_y);
                                    sum_reg[2] <= sum_reg[2] + SUM_W'(raw_z);
                                    cnt_reg    <= cnt_reg + 1'b1;
                                end
                            end
                            CMD_EVAL:
                            begin
                                if (cnt_reg == '0)
                                    status_reg <= 1'b1;
                                else
                                    state_reg <= S_MEAN;
                            end
                            CMD_CLEAR:
                            begin
                                for (int i = 0; i < 3; i++)
                                    sum_reg[i] <= '0;
                                cnt_reg <= '0;
                            end
                            default:
                                state_reg <= S_BIAS;
                        endcase
                    end
                end
                S_BIAS:
                begin
                    if (step_reg == '0)
                    begin
                        bias_reg[ax_reg] <= bias_sat;
                        if (ax_reg == 2'd2)
                        begin
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                            ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_MEAN:
                    if (step_reg == '0)
                        state_reg <= S_SCALE;
                S_SCALE:
                    if (step_reg == '0)
                        state_reg <= S_MIX1;
                S_MIX1:
                    if (step_reg == '0)
                        state_reg <= S_MIX2;
                S_MIX2:
                begin
                    if (step_reg == '0)
                    begin
                        rate_reg[ax_reg] <= mix_rate;
                        if (ax_reg == 2'd2)
                        begin
                            for (int i = 0; i < 3; i++)
                                sum_reg[i] <= '0;
                            cnt_reg   <= '0;
                            state_reg <= S_HCHK;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 2'd1;
                            state_reg <= S_MEAN;
                        end
                    end
                end
                S_HCHK:
                begin
                    if (rz_abs > RATE_W'(deadband_reg))
                        state_reg <= S_HMUL;
                    else
                    begin
                        last_reg  <= time_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_HMUL:
                    if (step_reg == '0)
                        state_reg <= S_HDIV;
                S_HDIV:
                begin
                    if (step_reg == '0)
                    begin
                        head_reg  <= neg_reg ? head_reg - $signed(hq) : head_reg + $signed(hq);
                        last_reg  <= time_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_load)
                        state_reg <= S_IDLE;
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath registers: divider, multiplier, captured operands, result word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                time_reg <= time_ms;
                // first axis into the divider
                dvd_reg  <= {sum_reg[0][SUM_W-1] ? SUM_W'(-sum_reg[0]) : SUM_W'(sum_reg[0]),
                             (WIDE_W-SUM_W)'(0)};
                neg_reg  <= sum_reg[0][SUM_W-1];
                rem_reg  <= '0;
                dsr_reg  <= (command == CMD_BIAS) ? bdiv : DIV_W'(cnt_reg);
                step_reg <= SUM_STEPS;
            end
            S_BIAS, S_MEAN, S_HDIV:
            begin
                if (step_reg != '0)
                begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    step_reg <= step_reg - 1'b1;
                end
                else if (state_reg == S_BIAS)
                begin
                    dvd_reg  <= {nxt_sum_abs, (WIDE_W-SUM_W)'(0)};
                    neg_reg  <= nxt_sum_neg;
                    rem_reg  <= '0;
                    step_reg <= SUM_STEPS;
                end
                else if (state_reg == S_MEAN)
                begin
                    acc_reg    <= '0;
                    mcand_reg  <= $signed(WIDE_W'(adc_abs));
                    mplier_reg <= 32'(scale_reg);
                    neg_reg    <= adc[SUM_W+1];
                    step_reg   <= SCALE_STEPS;
                end
            end
            S_SCALE, S_MIX1, S_MIX2, S_HMUL:
            begin
                if (step_reg != '0)
                begin
                    acc_reg    <= acc_next;
                    mcand_reg  <= mcand_reg <<< 1;
                    mplier_reg <= mplier_reg >> 1;
                    step_reg   <= step_reg - 1'b1;
                end
                else if (state_reg == S_SCALE)
                begin
                    nv_reg     <= nv_next;
                    acc_reg    <= '0;
                    mcand_reg  <= WIDE_W'(rate_reg[ax_reg]);
                    mplier_reg <= 32'(f_inv);
                    step_reg   <= MIX_STEPS;
                end
                else if (state_reg == S_MIX1)
                begin
                    mcand_reg  <= WIDE_W'(nv_reg);
                    mplier_reg <= 32'(f_w);
                    step_reg   <= MIX_STEPS;
                end
                else if (state_reg == S_MIX2)
                begin
                    // next axis mean
                    dvd_reg  <= {nxt_sum_abs, (WIDE_W-SUM_W)'(0)};
                    neg_reg  <= nxt_sum_neg;
                    rem_reg  <= '0;
                    step_reg <= SUM_STEPS;
                end
                else
                begin
                    // product / 1000
                    dvd_reg  <= acc_reg;
                    rem_reg  <= '0;
                    dsr_reg  <= MS_PER_S;
                    step_reg <= HDIV_STEPS;
                end
            end
            S_HCHK:
            begin
                acc_reg    <= '0;
                mcand_reg  <= $signed(WIDE_W'(rz_abs));
                mplier_reg <= time_reg - last_reg;
                neg_reg    <= rate_reg[2][RATE_W-1];
                step_reg   <= DT_STEPS;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    for (int i = 0; i < 3; i++)
                        out_rate_reg[i] <= rate_reg[i];
                    out_head_reg   <= head_reg;
                    out_status_reg <= status_reg;
                end
            end
            default:
                step_reg <= '0;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign rate_x    = out_rate_reg[0];
    assign rate_y    = out_rate_reg[1];
    assign rate_z    = out_rate_reg[2];
    assign heading   = out_head_reg;
    assign status    = out_status_reg;

    // Checks
    a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above limit");

    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        ax_reg != 2'd3)
        else $error("axis index out of range");

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEAN || state_reg == S_BIAS || state_reg == S_HDIV)
        |-> rem_reg < dsr_reg)
        else $error("divider remainder not below divisor");

    a_empty_eval: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_EVAL && cnt_reg == '0)
        |=> (state_reg == S_OUT && status_reg))
        else $error("evaluate with no samples not flagged");

endmodule

@@ dv/gre_checker.sv @@
// Checker for the gyro rate and heading estimator: predicts each result word and compares.
module gre_checker
    import gre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  cfg_idx_t    cfg_index,
    input  logic [30:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  cmd_t        command,
    input  raw_t        raw_x,
    input  raw_t        raw_y,
    input  raw_t        raw_z,
    input  logic [31:0] time_ms,
    input  logic        out_valid,
    input  logic        out_stall,
    input  rate_t       rate_x,
    input  rate_t       rate_y,
    input  rate_t       rate_z,
    input  rate_t       heading,
    input  logic        status,
    output int          fail_count,
    output int          pending
);

    localparam int SAMPLE_LIMIT = 1023;

    typedef struct packed {
        logic [31:0] rx;
        logic [31:0] ry;
        logic [31:0] rz;
        logic [31:0] hd;
        logic        st;
    } gyro_word_t;

    // predicted configuration and state
    logic [23:0]         scale_q;
    logic [16:0]         smooth_q;
    logic [30:0]         dband_q;
    logic [9:0]          bcount_q;
    logic signed [25:0]  sums_q [3];
    int unsigned         nsamp_q;
    logic signed [15:0]  bias_q [3];
    logic signed [31:0]  rates_q [3];
    logic [31:0]         heading_q;
    logic [31:0]         stamp_q;

    gyro_word_t expected_words[$];

    assign pending = expected_words.size();

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    task automatic clear_sums();
        for (int i = 0; i < 3; i++) sums_q[i] = '0;
        nsamp_q = 0;
    endtask

    // advance predicted state by one command and queue the word it yields
    task automatic apply_command(cmd_t c, raw_t x, raw_t y, raw_t z, logic [31:0] now);
        logic st;
        longint f, mean, adc, nv, mix, rz, db, inc, d;
        logic [31:0] dt;
        raw_t raws [3];
        gyro_word_t w;
        st = 1'b0;
        raws[0] = x; raws[1] = y; raws[2] = z;
        case (c)
            CMD_SAMPLE:
                if (nsamp_q < SAMPLE_LIMIT)
                begin
                    for (int i = 0; i < 3; i++) sums_q[i] = sums_q[i] + 26'(raws[i]);
                    nsamp_q++;
                end
            CMD_EVAL:
                if (nsamp_q == 0) st = 1'b1;
                else
                begin
                    f = smooth_q > 17'd65536 ? 65536 : longint'(smooth_q);
                    for (int i = 0; i < 3; i++)
                    begin
                        mean = longint'(sums_q[i]) / longint'(nsamp_q);
                        adc = (i == 2) ? longint'(bias_q[i]) - mean : mean - longint'(bias_q[i]);
                        nv = clamp((adc * longint'(scale_q)) / 256, -64'sd2147483648,
                                   64'sd2147483647);
                        mix = longint'(rates_q[i]) * (65536 - f) + nv * f;
                        rates_q[i] = 32'(mix / 65536);
                    end
                    clear_sums();
                    rz = longint'(rates_q[2]);
                    db = longint'(dband_q);
                    if (rz > db || rz < -db)
                    begin
                        dt = now - stamp_q;
                        inc = (rz * longint'(dt)) / 1000;
                        heading_q = heading_q + 32'(inc);
                    end
                    stamp_q = now;
                end
            CMD_CLEAR: clear_sums();
            default:
            begin
                d = bcount_q == 0 ? 1 : longint'(bcount_q);
                for (int i = 0; i < 3; i++)
                    bias_q[i] = 16'(clamp(longint'(sums_q[i]) / d, -32768, 32767));
                clear_sums();
            end
        endcase
        w.rx = rates_q[0]; w.ry = rates_q[1]; w.rz = rates_q[2];
        w.hd = heading_q;  w.st = st;
        expected_words.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_q = SCALE_RST; smooth_q = SMOOTH_RST;
            dband_q = DEADBAND_RST; bcount_q = BCOUNT_RST;
            clear_sums();
            for (int i = 0; i < 3; i++)
            begin
                bias_q[i] = '0; rates_q[i] = '0;
            end
            heading_q = '0; stamp_q = '0;
            fail_count = 0;
            expected_words.delete();
        end
        else
        begin
            // register writes
            if (cfg_we)
                case (cfg_index)
                    CFG_SCALE:    scale_q  = cfg_data[23:0];
                    CFG_SMOOTH:   smooth_q = cfg_data[16:0];
                    CFG_DEADBAND: dband_q  = cfg_data;
                    default:      bcount_q = cfg_data[9:0];
                endcase
            // result check before the new word is queued
            if (out_valid && !out_stall)
            begin
                gyro_word_t got, want;
                got = '{rate_x, rate_y, rate_z, heading, status};
                if (expected_words.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected result word %h", got);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch: rx %0d/%0d ry %0d/%0d rz %0d/%0d ",
                                      "hd %0d/%0d st %0b/%0b (exp/got)"},
                                     $signed(want.rx), $signed(got.rx), $signed(want.ry),
                                     $signed(got.ry), $signed(want.rz), $signed(got.rz),
                                     $signed(want.hd), $signed(got.hd), want.st, got.st);
                    end
                end
            end
            if (in_valid && !in_stall)
                apply_command(command, raw_x, raw_y, raw_z, time_ms);
        end
    end

endmodule

@@ dv/tb_gyro_rate_heading_estimator.sv @@
// Testbench top for the gyro rate and heading estimator: stimulus and verdict.
module tb_gyro_rate_heading_estimator;
    import gre_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_idx_t    cfg_index;
    logic [30:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    cmd_t        command;
    raw_t        raw_x, raw_y, raw_z;
    logic [31:0] time_ms;
    logic        out_valid;
    logic        out_stall;
    rate_t       rate_x, rate_y, rate_z, heading;
    logic        status;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    logic [31:0] clock_ms;

    gyro_rate_heading_estimator u_top (.*);
    gre_checker u_chk (.*);

    always
    begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 200);
    endfunction

    // receiver stall pattern
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 60) == 0)
            begin
                out_stall = 1'b1;
                repeat ($urandom_range(20, 300)) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb_gyro_rate_heading_estimator: errors");
            $finish;
        end
    end

    task automatic send_word(cmd_t c, raw_t x, raw_t y, raw_t z, logic [31:0] t);
        repeat (gap_len()) @(negedge clk);
        command = c; raw_x = x; raw_y = y; raw_z = z; time_ms = t;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_random(cmd_t c);
        clock_ms = clock_ms + ($urandom_range(0, 9) == 0 ? $urandom : $urandom_range(1, 50));
        send_word(c, raw_t'($urandom), raw_t'($urandom), raw_t'($urandom), clock_ms);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [30:0] val);
        // let the pipeline drain before touching a register
        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        cfg_index = idx; cfg_data = val; cfg_we = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // one random phase: burst of samples then an evaluate, bias or clear
    task automatic random_phase(int words);
        int n;
        n = 0;
        while (n < words)
        begin
            int burst, r;
            burst = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(0, 12);
            for (int i = 0; i < burst; i++) send_random(CMD_SAMPLE);
            r = $urandom_range(0, 9);
            if (r < 6) send_random(CMD_EVAL);
            else if (r < 8) send_random(CMD_BIAS);
            else send_random(CMD_CLEAR);
            n += burst + 1;
        end
    endtask

    initial
    begin
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = CFG_SCALE; cfg_data = '0;
        in_valid = 1'b0; command = CMD_SAMPLE; raw_x = '0; raw_y = '0; raw_z = '0;
        time_ms = '0; clock_ms = 32'd100;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes, every command, empty evaluate, saturation cases
        send_word(CMD_EVAL, 0, 0, 0, 32'd5);
        send_word(CMD_SAMPLE, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
        send_word(CMD_SAMPLE, 16'sh7fff, -16'sh8000, -16'sh8000, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'hffff_ffff);
        send_word(CMD_SAMPLE, -16'sh8000, 16'sh7fff, 16'sh7fff, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'd1000);
        send_word(CMD_SAMPLE, 16'sh7fff, 16'sh7fff, -16'sh8000, 0);
        send_word(CMD_CLEAR, 0, 0, 0, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'd2000);
        for (int i = 0; i < 4; i++) send_word(CMD_SAMPLE, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
        send_word(CMD_BIAS, 0, 0, 0, 0);
        send_word(CMD_SAMPLE, -16'sh8000, 16'sh7fff, -16'sh8000, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'd0);
        send_word(CMD_BIAS, 0, 0, 0, 0);

        // bias saturation with a divisor of one and zero divisor
        write_reg(CFG_BCOUNT, 31'd1);
        for (int i = 0; i < 3; i++) send_word(CMD_SAMPLE, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
        send_word(CMD_BIAS, 0, 0, 0, 0);
        write_reg(CFG_BCOUNT, 31'd0);
        send_word(CMD_SAMPLE, 16'sh1234, -16'sh0321, 16'sh0042, 0);
        send_word(CMD_BIAS, 0, 0, 0, 0);

        // sample-count saturation at full-scale input
        for (int i = 0; i < 1030; i++) send_word(CMD_SAMPLE, 16'sh7fff, -16'sh8000, 16'sh7fff, 0);
        send_word(CMD_EVAL, 0, 0, 0, 32'd3000);

        // random phases over several register settings, extremes included
        write_reg(CFG_BCOUNT, 31'd1023);
        write_reg(CFG_SCALE, 31'hffffff);
        write_reg(CFG_SMOOTH, 31'h1ffff);
        write_reg(CFG_DEADBAND, 31'd0);
        random_phase(130);
        write_reg(CFG_SCALE, 31'd0);
        write_reg(CFG_SMOOTH, 31'd0);
        write_reg(CFG_DEADBAND, 31'h7fffffff);
        random_phase(50);
        for (int k = 0; k < 6; k++)
        begin
            write_reg(CFG_SCALE, 31'($urandom_range(0, 24'hffffff)));
            write_reg(CFG_SMOOTH, 31'($urandom_range(0, 65536)));
            write_reg(CFG_DEADBAND, ($urandom_range(0, 3) == 0) ? 31'($urandom)
                                                                : 31'($urandom_range(0, 5000)));
            write_reg(CFG_BCOUNT, 31'($urandom_range(1, 1023)));
            random_phase(35);
        end

        // drain and settle
        while (pending != 0) @(negedge clk);
        repeat (600) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_gyro_rate_heading_estimator: clean");
        else
            $display("tb_gyro_rate_heading_estimator: errors");
        $finish;
    end

endmodule
